FILE: hw/rtl/mhcm_pkg.sv
// shared types, widths and constants of the per-block homography coordinate mapper
// no dependencies; imported by every module of the block
package mhcm_pkg;

  localparam int QUAD_STEP   = 8;
  localparam int COORD_BITS  = 12;
  localparam int MESH_BLOCKS = QUAD_STEP * QUAD_STEP;
  localparam int BLOCK_W     = 6;
  localparam int TABLE_DEPTH = 64;
  localparam int PIX_W       = 12;
  localparam int COEF_W      = 48;
  localparam int OUT_W       = 32;
  localparam int NUM_SLOTS   = 16;
  localparam int SLOT_W      = 4;
  localparam int COORDS      = 4;

  // Q32 sums to a Q16 quotient, with one extra bit for the rounding half
  localparam int FRAC_SHIFT = 17;
  localparam int PROD_W     = COEF_W + COORD_BITS + 1;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = SUM_W + FRAC_SHIFT + 1;
  localparam int DEN_W      = SUM_W + 1;
  localparam int QUOT_W     = 32;
  localparam int REM_W      = DEN_W + QUOT_W;

  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_MAP   = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic [BLOCK_W-1:0]       block_index;
    logic                     matrix_select;
    logic [2:0]               coeff_slot;
    logic signed [COEF_W-1:0] coeff_value;
    logic [PIX_W-1:0]         pixel_x;
    logic [PIX_W-1:0]         pixel_y;
  } mhcm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] fwd_x;
    logic signed [OUT_W-1:0] fwd_y;
    logic signed [OUT_W-1:0] inv_x;
    logic signed [OUT_W-1:0] inv_y;
    logic                    fwd_bad;
    logic                    inv_bad;
  } mhcm_out_t;

  // one coordinate's division, as magnitudes and signs
  typedef struct packed {
    logic [SUM_W-1:0] an;
    logic [SUM_W-1:0] ad;
    logic             nneg;
    logic             neg;
  } mhcm_coord_job_t;

  // coordinate order: forward x, forward y, inverse x, inverse y
  typedef struct packed {
    logic                               blk_ok;
    mhcm_coord_job_t [COORDS-1:0]       coord;
  } mhcm_job_t;

endpackage

FILE: hw/rtl/mhcm_front.sv
// front end: accepts items, holds the coefficient table, forms numerators and denominators
// depends on mhcm_pkg
module mhcm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  mhcm_pkg::mhcm_in_t item,
  input  logic               q_pop,
  output logic               job_valid,
  output mhcm_pkg::mhcm_job_t job
);
  import mhcm_pkg::*;

  logic              accept;
  logic              blk_ok_in;
  logic              wr;
  logic [SLOT_W-1:0] wr_slot;
  logic [CNT_W-1:0]  outstanding;
  logic [CNT_W-1:0]  outstanding_next;
  logic              map_in;

  assign accept    = push && !full;
  assign blk_ok_in = int'(item.block_index) < MESH_BLOCKS;
  assign map_in    = accept && (item.cmd == CMD_MAP);
  assign wr        = accept && (item.cmd == CMD_WRITE) && blk_ok_in;
  assign wr_slot   = {item.matrix_select, item.coeff_slot};

  // map items inside the front end or the queue, so the queue never overflows
  assign full = outstanding >= CNT_W'(QUEUE_DEPTH);
  assign outstanding_next = outstanding + CNT_W'(map_in) - CNT_W'(q_pop);

  // stage 1: table read
  logic signed [COEF_W-1:0] rd_coef [NUM_SLOTS];
  logic                     v1, ok1;
  logic [COORD_BITS-1:0]    x1, y1;

  for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
    logic [COEF_W-1:0] mem [TABLE_DEPTH];
    always_ff @(posedge clk) begin
      if (wr && wr_slot == SLOT_W'(s)) begin
        mem[item.block_index] <= item.coeff_value;
      end
      if (accept) begin
        rd_coef[s] <= mem[item.block_index];
      end
    end
  end

  always_ff @(posedge clk) begin
    ok1 <= blk_ok_in;
    x1  <= COORD_BITS'(item.pixel_x);
    y1  <= COORD_BITS'(item.pixel_y);
  end

  // stage 2: products
  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PROD_W-1:0]   prod [2][6];
  logic signed [COEF_W-1:0]   kc [2][2];
  logic                       v2, ok2;

  assign xs = {1'b0, x1};
  assign ys = {1'b0, y1};

  for (genvar m = 0; m < 2; m++) begin : g_mul
    always_ff @(posedge clk) begin
      prod[m][0] <= rd_coef[m*8+0] * xs;
      prod[m][1] <= rd_coef[m*8+1] * ys;
      prod[m][2] <= rd_coef[m*8+3] * xs;
      prod[m][3] <= rd_coef[m*8+4] * ys;
      prod[m][4] <= rd_coef[m*8+6] * xs;
      prod[m][5] <= rd_coef[m*8+7] * ys;
      kc[m][0]   <= rd_coef[m*8+2];
      kc[m][1]   <= rd_coef[m*8+5];
    end
  end

  always_ff @(posedge clk) begin
    ok2 <= ok1;
  end

  // stage 3: sums, denominator carries the fixed ninth coefficient
  localparam logic signed [SUM_W-1:0] ONE_Q32 = SUM_W'(1) << 32;
  logic signed [SUM_W-1:0] snum [2][2];
  logic signed [SUM_W-1:0] sden [2];
  logic                    v3, ok3;

  for (genvar m = 0; m < 2; m++) begin : g_sum
    always_ff @(posedge clk) begin
      snum[m][0] <= SUM_W'(prod[m][0]) + SUM_W'(prod[m][1]) + SUM_W'(kc[m][0]);
      snum[m][1] <= SUM_W'(prod[m][2]) + SUM_W'(prod[m][3]) + SUM_W'(kc[m][1]);
      sden[m]    <= SUM_W'(prod[m][4]) + SUM_W'(prod[m][5]) + ONE_Q32;
    end
  end

  always_ff @(posedge clk) begin
    ok3 <= ok2;
  end

  // stage 4: magnitudes and signs
  always_ff @(posedge clk) begin
    for (int c = 0; c < COORDS; c++) begin
      job.coord[c].an   <= snum[c >> 1][c & 1][SUM_W-1] ? SUM_W'(-snum[c >> 1][c & 1])
                                                        : SUM_W'(snum[c >> 1][c & 1]);
      job.coord[c].ad   <= sden[c >> 1][SUM_W-1] ? SUM_W'(-sden[c >> 1])
                                                 : SUM_W'(sden[c >> 1]);
      job.coord[c].nneg <= snum[c >> 1][c & 1][SUM_W-1];
      job.coord[c].neg  <= snum[c >> 1][c & 1][SUM_W-1] ^ sden[c >> 1][SUM_W-1];
    end
    job.blk_ok <= ok3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      job_valid   <= 1'b0;
    end else begin
      outstanding <= outstanding_next;
      v1          <= map_in;
      v2          <= v1;
      v3          <= v2;
      job_valid   <= v3;
    end
  end

endmodule

FILE: hw/rtl/mhcm_queue.sv
// short fifo of division jobs between the front end and the divider
// depends on mhcm_pkg
module mhcm_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  mhcm_pkg::mhcm_job_t din,
  input  logic                pop,
  output mhcm_pkg::mhcm_job_t dout,
  output logic                empty
);
  import mhcm_pkg::*;

  mhcm_job_t         mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  cnt;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign empty = (cnt == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      cnt <= cnt + CNT_W'(push) - CNT_W'(pop);
    end
  end

endmodule

FILE: hw/rtl/mhcm_back.sv
// back end: pipelined restoring dividers, rounding, saturation and the result register
// depends on mhcm_pkg
module mhcm_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  mhcm_pkg::mhcm_job_t q_head,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output mhcm_pkg::mhcm_out_t result
);
  import mhcm_pkg::*;

  localparam int LAST = QUOT_W + 1;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [QUOT_W-1:0] q;
    logic              ovf;
    logic              zero_den;
    logic              an_zero;
    logic              nneg;
    logic              neg;
  } div_t;

  typedef struct packed {
    logic [OUT_W-1:0] v;
    logic             bad;
  } coord_res_t;

  div_t [COORDS-1:0] sd [LAST+1];
  logic              sv [LAST+1];
  logic              sok [LAST+1];
  logic              out_valid;
  logic              adv;

  // the whole divider moves together whenever the result register can take a value
  assign adv   = !out_valid || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !out_valid;

  // stage 0: rounding numerator (2|n| + |d|) / 2|d| set up
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < COORDS; c++) begin
        sd[0][c].rem      <= REM_W'((NUM_W'(q_head.coord[c].an) << FRAC_SHIFT)
                                    + NUM_W'(q_head.coord[c].ad));
        sd[0][c].den      <= DEN_W'(q_head.coord[c].ad) << 1;
        sd[0][c].q        <= '0;
        sd[0][c].ovf      <= 1'b0;
        sd[0][c].zero_den <= (q_head.coord[c].ad == '0);
        sd[0][c].an_zero  <= (q_head.coord[c].an == '0);
        sd[0][c].nneg     <= q_head.coord[c].nneg;
        sd[0][c].neg      <= q_head.coord[c].neg;
      end
      sok[0] <= q_head.blk_ok;
    end
  end

  // stage 1 flags a quotient of 2^32 or more, later stages take one quotient bit each
  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    div_t nxt [COORDS];
    for (genvar c = 0; c < COORDS; c++) begin : g_coord
      if (k == 1) begin : g_ovf
        always_comb begin
          nxt[c]     = sd[k-1][c];
          nxt[c].ovf = sd[k-1][c].rem >= (REM_W'(sd[k-1][c].den) << QUOT_W);
        end
      end else begin : g_bit
        localparam int BIT = LAST - k;
        logic [REM_W-1:0] sh;
        assign sh = REM_W'(sd[k-1][c].den) << BIT;
        always_comb begin
          nxt[c] = sd[k-1][c];
          if (sd[k-1][c].rem >= sh) begin
            nxt[c].rem    = sd[k-1][c].rem - sh;
            nxt[c].q[BIT] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int c = 0; c < COORDS; c++) begin
          sd[k][c] <= nxt[c];
        end
        sok[k] <= sok[k-1];
      end
    end
  end

  function automatic coord_res_t finish(input div_t d, input logic ok);
    coord_res_t r;
    r.v   = '0;
    r.bad = 1'b1;
    if (!ok) begin
      r.v = '0;
    end else if (d.zero_den) begin
      r.v = d.an_zero ? '0 : (d.nneg ? SAT_MIN : SAT_MAX);
    end else if (d.neg) begin
      if (d.ovf || d.q > SAT_MIN) begin
        r.v = SAT_MIN;
      end else begin
        r.v   = OUT_W'('0) - d.q;
        r.bad = 1'b0;
      end
    end else begin
      if (d.ovf || d.q[QUOT_W-1]) begin
        r.v = SAT_MAX;
      end else begin
        r.v   = d.q;
        r.bad = 1'b0;
      end
    end
    return r;
  endfunction

  coord_res_t res [COORDS];
  for (genvar c = 0; c < COORDS; c++) begin : g_fin
    assign res[c] = finish(sd[LAST][c], sok[LAST]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.fwd_x   <= res[0].v;
      result.fwd_y   <= res[1].v;
      result.inv_x   <= res[2].v;
      result.inv_y   <= res[3].v;
      result.fwd_bad <= res[0].bad | res[1].bad;
      result.inv_bad <= res[2].bad | res[3].bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LAST; k++) begin
        sv[k] <= 1'b0;
      end
      out_valid <= 1'b0;
    end else if (adv) begin
      sv[0] <= !q_empty;
      for (int k = 1; k <= LAST; k++) begin
        sv[k] <= sv[k-1];
      end
      out_valid <= sv[LAST];
    end
  end

endmodule

FILE: hw/rtl/mesh_homography_coord_mapper.sv
// per-block homography coordinate mapper: top level
// joins mhcm_front, mhcm_queue and mhcm_back; depends on mhcm_pkg
//
// input channel (push/full/item): an item is taken on a clock edge with push high
// and full low. a write item loads one Q15.32 coefficient of the forward or inverse
// homography of one mesh block and gives no result. a map item gives one result:
// the forward and inverse images of the pixel in Q15.16, with a bad flag per matrix
// for a zero denominator, a saturated coordinate or a block outside the mesh.
// result channel (empty/pop/result): the oldest result is shown while empty is low
// and is taken on an edge with pop high.
// throughput is one item per clock while full is low. a map item passes through
// four front-end stages (table read, multiply, sum, magnitude), the job queue, and
// a divider with a set-up stage, an overflow stage and stages that resolve one
// quotient bit per stage, then the result register.
// when the receiver stalls the divider holds; the queue and front end keep taking
// items until eight map items wait in front of the divider, then full rises.
// reset empties the pipeline and the queue; the coefficient table is not cleared and
// must be written before it is used.
module mesh_homography_coord_mapper (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  mhcm_pkg::mhcm_in_t  item,
  input  logic                pop,
  output logic                empty,
  output mhcm_pkg::mhcm_out_t result
);
  import mhcm_pkg::*;

  logic      job_valid;
  mhcm_job_t job;
  mhcm_job_t q_head;
  logic      q_empty;
  logic      q_pop;

  mhcm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .q_pop     (q_pop),
    .job_valid (job_valid),
    .job       (job)
  );

  mhcm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (job_valid),
    .din   (job),
    .pop   (q_pop),
    .dout  (q_head),
    .empty (q_empty)
  );

  mhcm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

FILE: hw/rtl/mhcm_checker.sv
// port-level checks of the coordinate mapper, bound to the top level
// depends on mhcm_pkg and mesh_homography_coord_mapper
module mhcm_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input mhcm_pkg::mhcm_in_t  item,
  input logic                pop,
  input logic                empty,
  input mhcm_pkg::mhcm_out_t result
);
  import mhcm_pkg::*;

  // a waiting result is held until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("result changed while waiting");

  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result shown right after reset");

  a_rst_ready: assert property (@(posedge clk) rst |=> !full)
    else $error("input blocked right after reset");

  // right after reset, no result can come out of the pipeline without an item going in
  a_no_phantom: assert property (@(posedge clk) (rst ##1 !push) |=> empty)
    else $error("result without an item");

  // an invalid-looking item value must not matter while blocked
  a_item_known: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |-> !$isunknown(item.cmd))
    else $error("command unknown on accept");

endmodule

bind mesh_homography_coord_mapper mhcm_checker u_chk (.*);
